// ===== hdl/spr_pkg.sv =====
`default_nettype none

package spr_pkg;

	// Default and fixed sizes.
	localparam int unsigned MAX_PATTERN_DEF = 8;
	localparam int unsigned REP_MAX         = 8;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned LEN_W           = 4;
	localparam int unsigned REP_IDX_W       = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES      = 2'd0,
		CFG_PATTERN_LENGTH     = 2'd1,
		CFG_REPLACEMENT_BYTES  = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RELEASE,
		ST_REPL,
		ST_FLUSH,
		ST_MARK
	} state_t;

	// Source of the next output word.
	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_HELD,
		EMIT_REP,
		EMIT_MARK
	} emit_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      append;
		emit_sel_t emit_sel;
		logic      emit_final;
		logic      clear_count;
		logic      rep_clear;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic count_one;
		logic prefix;
		logic full;
		logic item_last;
		logic rlen_zero;
		logic rep_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/spr_if.sv =====
`default_nettype none

// Source byte channel.
interface spr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// Result channel.
interface spr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;

	modport source (output valid, output out_byte, output byte_valid, output out_last,
		input ready);
	modport sink (input valid, input out_byte, input byte_valid, input out_last,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/spr_datapath.sv =====
`default_nettype none

module spr_datapath #(
	parameter int unsigned MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [spr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [7:0]                     in_byte,
	input  wire logic                           in_last,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [7:0]                          out_byte,
	output logic                                byte_valid,
	output logic                                out_last,
	input  wire spr_pkg::dp_cmd_t               cmd,
	output spr_pkg::dp_status_t                 sts
);

	localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned PAT_W = 8 * MAX_PATTERN;
	localparam int unsigned REP_W = 8 * spr_pkg::REP_MAX;

	logic [PAT_W-1:0]              pat_q;
	logic [spr_pkg::LEN_W-1:0]     pat_len_q;
	logic [REP_W-1:0]              rep_q;
	logic [spr_pkg::LEN_W-1:0]     rep_len_q;
	logic [7:0]                    held_q [MAX_PATTERN];
	logic [CNT_W-1:0]              cnt_q;
	logic                          last_q;
	logic [spr_pkg::REP_IDX_W-1:0] rep_idx_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          byte_valid_q;
	logic                          out_last_q;

	logic [CNT_W-1:0]          plen;
	logic [spr_pkg::LEN_W-1:0] rlen;
	logic [MAX_PATTERN-1:0]    byte_ok;
	logic                      pat_write;
	logic                      emit_held;
	logic                      emit_rep;

	assign emit_held = (cmd.emit_sel == spr_pkg::EMIT_HELD);
	assign emit_rep  = (cmd.emit_sel == spr_pkg::EMIT_REP);
	assign pat_write = cfg_we &&
		((spr_pkg::cfg_reg_t'(cfg_index) == spr_pkg::CFG_PATTERN_BYTES) ||
		 (spr_pkg::cfg_reg_t'(cfg_index) == spr_pkg::CFG_PATTERN_LENGTH));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			pat_len_q <= spr_pkg::LEN_W'(1);
			rep_q     <= '0;
			rep_len_q <= '0;
		end else if (cfg_we) begin
			unique case (spr_pkg::cfg_reg_t'(cfg_index))
				spr_pkg::CFG_PATTERN_BYTES:      pat_q     <= cfg_wdata[PAT_W-1:0];
				spr_pkg::CFG_PATTERN_LENGTH:     pat_len_q <= cfg_wdata[spr_pkg::LEN_W-1:0];
				spr_pkg::CFG_REPLACEMENT_BYTES:  rep_q     <= cfg_wdata[REP_W-1:0];
				spr_pkg::CFG_REPLACEMENT_LENGTH: rep_len_q <= cfg_wdata[spr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective lengths: a zero pattern length counts as one, both saturate.
	always_comb begin
		if (pat_len_q == '0) begin
			plen = CNT_W'(1);
		end else if (pat_len_q > spr_pkg::LEN_W'(MAX_PATTERN)) begin
			plen = CNT_W'(MAX_PATTERN);
		end else begin
			plen = CNT_W'(pat_len_q);
		end
		if (rep_len_q > spr_pkg::LEN_W'(spr_pkg::REP_MAX)) begin
			rlen = spr_pkg::LEN_W'(spr_pkg::REP_MAX);
		end else begin
			rlen = rep_len_q;
		end
	end

	// Compare every held byte with its pattern byte in parallel.
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			byte_ok[i] = (CNT_W'(i) >= cnt_q) || (CNT_W'(i) >= plen) ||
				(held_q[i] == pat_q[8*i +: 8]);
		end
	end

	// Held bytes: append at the fill position, shift out at the front.
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			held_q[cnt_q[IDX_W-1:0]] <= in_byte;
		end else if (emit_held) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				held_q[i] <= held_q[i+1];
			end
		end
	end

	// Fill count of the held bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			priority if (pat_write || cmd.clear_count) begin
				cnt_q <= '0;
			end else if (cmd.append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (emit_held) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// End mark of the word under work.
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			last_q <= in_last;
		end
	end

	// Replacement byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_idx_q <= '0;
		end else if (cmd.rep_clear) begin
			rep_idx_q <= '0;
		end else if (emit_rep) begin
			rep_idx_q <= rep_idx_q + spr_pkg::REP_IDX_W'(1);
		end
	end

	// Output register: loads when empty or when its word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sel != spr_pkg::EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.emit_sel)
			spr_pkg::EMIT_HELD: begin
				out_byte_q   <= held_q[0];
				byte_valid_q <= 1'b1;
				out_last_q   <= cmd.emit_final;
			end
			spr_pkg::EMIT_REP: begin
				out_byte_q   <= rep_q[{rep_idx_q, 3'b000} +: 8];
				byte_valid_q <= 1'b1;
				out_last_q   <= cmd.emit_final;
			end
			spr_pkg::EMIT_MARK: begin
				out_byte_q   <= '0;
				byte_valid_q <= 1'b0;
				out_last_q   <= cmd.emit_final;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign out_last   = out_last_q;

	// Status toward the controller.
	always_comb begin
		sts.count_zero = (cnt_q == '0);
		sts.count_one  = (cnt_q == CNT_W'(1));
		sts.prefix     = &byte_ok;
		sts.full       = (cnt_q >= plen);
		sts.item_last  = last_q;
		sts.rlen_zero  = (rlen == '0);
		sts.rep_last   = (({1'b0, rep_idx_q} + spr_pkg::LEN_W'(1)) == rlen);
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ===== hdl/spr_ctrl.sv =====
`default_nettype none

module spr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire spr_pkg::dp_status_t sts,
	output spr_pkg::dp_cmd_t         cmd
);

	spr_pkg::state_t state_q;
	spr_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = spr_pkg::ST_EVAL;
				end
			end
			spr_pkg::ST_EVAL: begin
				priority if (sts.count_zero) begin
					state_d = spr_pkg::ST_IDLE;
				end else if (!sts.prefix) begin
					state_d = spr_pkg::ST_RELEASE;
				end else if (sts.full && !sts.rlen_zero) begin
					state_d = spr_pkg::ST_REPL;
				end else if (sts.full) begin
					state_d = sts.item_last ? spr_pkg::ST_MARK : spr_pkg::ST_IDLE;
				end else begin
					state_d = sts.item_last ? spr_pkg::ST_FLUSH : spr_pkg::ST_IDLE;
				end
			end
			spr_pkg::ST_RELEASE: begin
				if (sts.out_free) begin
					state_d = spr_pkg::ST_EVAL;
				end
			end
			spr_pkg::ST_REPL: begin
				if (sts.out_free && sts.rep_last) begin
					state_d = spr_pkg::ST_IDLE;
				end
			end
			spr_pkg::ST_FLUSH: begin
				if (sts.out_free && sts.count_one) begin
					state_d = spr_pkg::ST_IDLE;
				end
			end
			spr_pkg::ST_MARK: begin
				if (sts.out_free) begin
					state_d = spr_pkg::ST_IDLE;
				end
			end
			default: state_d = spr_pkg::ST_IDLE;
		endcase
	end

	// Outputs: words go only to a free output register; bytes are taken in idle.
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		cmd.emit_sel = spr_pkg::EMIT_NONE;
		unique case (state_q)
			spr_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.append = in_valid;
			end
			spr_pkg::ST_EVAL: begin
				if (!sts.count_zero && sts.prefix && sts.full) begin
					cmd.clear_count = sts.rlen_zero;
					cmd.rep_clear   = !sts.rlen_zero;
				end
			end
			spr_pkg::ST_RELEASE: begin
				if (sts.out_free) begin
					cmd.emit_sel   = spr_pkg::EMIT_HELD;
					cmd.emit_final = sts.item_last && sts.count_one;
				end
			end
			spr_pkg::ST_REPL: begin
				if (sts.out_free) begin
					cmd.emit_sel    = spr_pkg::EMIT_REP;
					cmd.emit_final  = sts.item_last && sts.rep_last;
					cmd.clear_count = sts.rep_last;
				end
			end
			spr_pkg::ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.emit_sel   = spr_pkg::EMIT_HELD;
					cmd.emit_final = sts.count_one;
				end
			end
			spr_pkg::ST_MARK: begin
				if (sts.out_free) begin
					cmd.emit_sel   = spr_pkg::EMIT_MARK;
					cmd.emit_final = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Between words the held bytes are always a proper prefix of the pattern.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spr_pkg::ST_IDLE) |-> (sts.prefix && !sts.full))
		else $error("held bytes are not a proper pattern prefix while idle");

	// A word is emitted only into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sel != spr_pkg::EMIT_NONE) |-> sts.out_free)
		else $error("word emitted into an occupied output register");

	// A bare end marker is given only when no held byte remains.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sel == spr_pkg::EMIT_MARK) |-> sts.count_zero)
		else $error("end marker emitted with held bytes left");

	// A final word ends the string and leaves no held byte behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_sel != spr_pkg::EMIT_NONE) && cmd.emit_final) |=>
		sts.count_zero)
		else $error("held bytes left after a final word");

endmodule

`default_nettype wire

// ===== hdl/stream_pattern_replace.sv =====
`default_nettype none

// Channel   Dir   Handshake      Word
// feed      in    valid/ready    in_byte[7:0], in_last
// result    out   valid/ready    out_byte[7:0], byte_valid, out_last
// config    in    cfg_we         cfg_index[1:0], cfg_wdata[63:0]
//
// Each source byte is accepted into the held bytes, then compared.
// Each released byte is emitted, then the rest are compared again; replacement or
// flushed bytes follow; the single output register holds one word until taken.
// Reset clears the controller, the fill count and the configuration to defaults.
// A stalled result word holds the controller; no new byte is taken until the
// words of the current byte are all in the output register.

module stream_pattern_replace #(
	parameter int unsigned MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [spr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	spr_in_if.sink                              feed,
	spr_out_if.source                           result
);

	spr_pkg::dp_cmd_t    cmd;
	spr_pkg::dp_status_t sts;

	// Sequencer for compare, release, replace, flush and end mark.
	spr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feed.valid),
		.in_ready (feed.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Held bytes, configuration, comparators and output register.
	spr_datapath #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (feed.in_byte),
		.in_last    (feed.in_last),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_byte   (result.out_byte),
		.byte_valid (result.byte_valid),
		.out_last   (result.out_last),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

	localparam int          SETTLE_CYCLES  = 40;
	localparam int          LONG_HOLD      = 300;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          RAND_PHASES    = 12;
	localparam int          PHASE_BYTES    = 10;
	localparam int          HOLD_PHASE     = 3;
	localparam int          PAUSE_PHASE    = 6;
	localparam int          DIR_ROWS       = 28;

	// One word on the result channel.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
	} out_word_t;

	typedef enum logic {
		STEP_WRITE,
		STEP_BYTE
	} step_kind_t;

	// One row of the directed plan: a register write or a source byte.
	typedef struct {
		step_kind_t        kind;
		spr_pkg::cfg_reg_t idx;
		logic [63:0]       data;
		logic              last;
		bit                typed;
		out_word_t         want;
	} plan_row_t;

	localparam out_word_t NO_WORD = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [spr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [spr_pkg::CFG_DATA_W-1:0] cfg_wdata;

	spr_in_if  feed_ch ();
	spr_out_if result_ch ();

	stream_pattern_replace i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.feed      (feed_ch),
		.result    (result_ch)
	);

	always #5 clk = ~clk;

	// Shadow copy of the configuration and of the bytes held as a partial match.
	logic [63:0] m_pattern     = 64'd0;
	logic [3:0]  m_pattern_len = 4'd1;
	logic [63:0] m_repl        = 64'd0;
	logic [3:0]  m_repl_len    = 4'd0;
	logic [7:0]  pend_bytes [8];
	int          pend_count    = 0;

	out_word_t   expected_words [$];
	logic [7:0]  text_chunk [$];
	int          mismatches    = 0;
	int          quiet_cycles  = 0;
	bit          tx_idle_on    = 1'b1;
	bit          rx_idle_on    = 1'b1;
	bit          hold_off_req  = 1'b0;

	// Directed plan. Expected words are typed in where they are obvious.
	plan_row_t dir_plan [DIR_ROWS] = '{
		// After reset the pattern is one zero byte and the replacement is empty.
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1}},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
		// Pattern "ab" replaced by "XYZ"; the length word carries junk in its upper bits.
		'{STEP_WRITE, spr_pkg::CFG_PATTERN_BYTES, 64'h6261, 1'b0, 1'b0, NO_WORD},
		'{STEP_WRITE, spr_pkg::CFG_PATTERN_LENGTH, 64'hDEAD_BEEF_0000_0002, 1'b0, 1'b0,
			NO_WORD},
		'{STEP_WRITE, spr_pkg::CFG_REPLACEMENT_BYTES, 64'h5A_5958, 1'b0, 1'b0, NO_WORD},
		'{STEP_WRITE, spr_pkg::CFG_REPLACEMENT_LENGTH, 64'h3, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h62, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h63, 1'b1, 1'b0, NO_WORD},
		// A held prefix is discarded by a length write; zero length acts as one.
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h61, 1'b0, 1'b0, NO_WORD},
		'{STEP_WRITE, spr_pkg::CFG_PATTERN_LENGTH, 64'h0, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'h62, 1'b1, 1'b1, '{8'h62, 1'b1, 1'b1}},
		// All-ones extremes with both lengths above their limits.
		'{STEP_WRITE, spr_pkg::CFG_REPLACEMENT_LENGTH, 64'hF, 1'b0, 1'b0, NO_WORD},
		'{STEP_WRITE, spr_pkg::CFG_REPLACEMENT_BYTES, '1, 1'b0, 1'b0, NO_WORD},
		'{STEP_WRITE, spr_pkg::CFG_PATTERN_BYTES, '1, 1'b0, 1'b0, NO_WORD},
		'{STEP_WRITE, spr_pkg::CFG_PATTERN_LENGTH, 64'hF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b0, 1'b0, NO_WORD},
		'{STEP_BYTE, spr_pkg::CFG_PATTERN_BYTES, 64'hFF, 1'b1, 1'b0, NO_WORD}
	};

	function automatic int unsigned eff_pat_len();
		if (m_pattern_len == 4'd0) begin
			return 1;
		end
		if (m_pattern_len > spr_pkg::MAX_PATTERN_DEF) begin
			return spr_pkg::MAX_PATTERN_DEF;
		end
		return m_pattern_len;
	endfunction

	function automatic void queue_word(input logic [7:0] b, input logic v);
		out_word_t w;
		w = '{out_byte: b, byte_valid: v, out_last: 1'b0};
		expected_words.insert(expected_words.size(), w);
	endfunction

	function automatic void drop_pending(input int unsigned k);
		int unsigned i;
		if (k >= pend_count) begin
			pend_count = 0;
		end else begin
			for (i = 0; i + k < pend_count; i++) begin
				pend_bytes[i] = pend_bytes[i + k];
			end
			pend_count -= k;
		end
	endfunction

	// Work out the words that one accepted source byte produces.
	function automatic void predict_replace(input logic [7:0] b, input logic last);
		int unsigned plen;
		int unsigned rlen;
		int unsigned cmp;
		int unsigned i;
		int unsigned produced;
		bit          is_prefix;
		bit          settled;
		plen = eff_pat_len();
		rlen = (m_repl_len > spr_pkg::REP_MAX) ? spr_pkg::REP_MAX : m_repl_len;
		produced = 0;
		settled = 1'b0;
		if (pend_count < 8) begin
			pend_bytes[pend_count] = b;
			pend_count++;
		end
		// Replace full matches, release bytes that cannot start one.
		while (pend_count > 0 && !settled) begin
			cmp = (pend_count < plen) ? pend_count : plen;
			is_prefix = 1'b1;
			for (i = 0; i < cmp; i++) begin
				if (pend_bytes[i] != m_pattern[8*i +: 8]) begin
					is_prefix = 1'b0;
				end
			end
			if (is_prefix && pend_count >= plen) begin
				for (i = 0; i < rlen; i++) begin
					queue_word(m_repl[8*i +: 8], 1'b1);
					produced++;
				end
				drop_pending(plen);
			end else if (is_prefix) begin
				settled = 1'b1;
			end else begin
				queue_word(pend_bytes[0], 1'b1);
				produced++;
				drop_pending(1);
			end
		end
		// End of string: flush what is held and mark the final word.
		if (last) begin
			for (i = 0; i < pend_count; i++) begin
				queue_word(pend_bytes[i], 1'b1);
				produced++;
			end
			pend_count = 0;
			if (produced == 0) begin
				queue_word(8'h00, 1'b0);
			end
			expected_words[expected_words.size() - 1].out_last = 1'b1;
		end
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Source text: mostly whole or partial copies of the pattern, some noise.
	function automatic logic [7:0] next_text_byte();
		int unsigned r;
		int unsigned n;
		int unsigned plen;
		int unsigned i;
		if (text_chunk.size() == 0) begin
			plen = eff_pat_len();
			r = $urandom_range(0, 99);
			if (r < 45) begin
				n = plen;
			end else if (r < 70) begin
				n = $urandom_range(1, plen);
			end else begin
				n = 0;
			end
			for (i = 0; i < n; i++) begin
				text_chunk.insert(text_chunk.size(), m_pattern[8*i +: 8]);
			end
			if (n == 0) begin
				if (r < 88) begin
					text_chunk.insert(text_chunk.size(),
						m_pattern[8*$urandom_range(0, plen - 1) +: 8]);
				end else begin
					text_chunk.insert(text_chunk.size(), 8'($urandom));
				end
			end
		end
		return text_chunk.pop_front();
	endfunction

	task automatic write_reg(input spr_pkg::cfg_reg_t idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			spr_pkg::CFG_PATTERN_BYTES: begin
				m_pattern = val;
				pend_count = 0;
			end
			spr_pkg::CFG_PATTERN_LENGTH: begin
				m_pattern_len = val[3:0];
				pend_count = 0;
			end
			spr_pkg::CFG_REPLACEMENT_BYTES: begin
				m_repl = val;
			end
			spr_pkg::CFG_REPLACEMENT_LENGTH: begin
				m_repl_len = val[3:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// Offer one source byte, after a random gap while source idles are on, and predict once it is taken.
	task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
		input out_word_t want);
		int unsigned gap;
		int unsigned mark;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			feed_ch.valid <= 1'b0;
			feed_ch.in_byte <= 8'($urandom);
			feed_ch.in_last <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		feed_ch.valid <= 1'b1;
		feed_ch.in_byte <= b;
		feed_ch.in_last <= last;
		do begin
			@(posedge clk);
		end while (!feed_ch.ready);
		mark = expected_words.size();
		predict_replace(b, last);
		if (typed) begin
			while (expected_words.size() > mark) begin
				void'(expected_words.pop_back());
			end
			expected_words.insert(expected_words.size(), want);
		end
	endtask

	task automatic feed_quiet();
		feed_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Let the block drain before touching the registers.
	task automatic settle();
		feed_quiet();
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus: reset, directed plan, then random phases.
	initial begin
		int          row;
		int          phase;
		int          sent;
		int          goal;
		int          str_len;
		int          k;
		int          i;
		logic [3:0]  regs_mask;
		logic [63:0] word;
		logic [7:0]  a0;
		logic [7:0]  a1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = spr_pkg::CFG_PATTERN_BYTES;
		cfg_wdata = '0;
		feed_ch.valid = 1'b0;
		feed_ch.in_byte = 8'h00;
		feed_ch.in_last = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIR_ROWS; row++) begin
			if (dir_plan[row].kind == STEP_WRITE) begin
				settle();
				write_reg(dir_plan[row].idx, dir_plan[row].data);
			end else begin
				push_byte(dir_plan[row].data[7:0], dir_plan[row].last, dir_plan[row].typed,
					dir_plan[row].want);
			end
		end

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			settle();
			regs_mask = (phase == 0) ? 4'hF : 4'($urandom_range(1, 15));
			// Patterns mostly over a two-byte alphabet so that repeats and near misses are common.
			if (regs_mask[0]) begin
				a0 = 8'($urandom);
				a1 = ($urandom_range(0, 1) != 0) ? (a0 ^ 8'(1 << $urandom_range(0, 7)))
					: 8'($urandom);
				if ($urandom_range(0, 5) == 0) begin
					a0 = 8'h00;
					a1 = 8'hFF;
				end
				for (i = 0; i < 8; i++) begin
					if ($urandom_range(0, 4) == 0) begin
						word[8*i +: 8] = 8'($urandom);
					end else begin
						word[8*i +: 8] = ($urandom_range(0, 1) != 0) ? a0 : a1;
					end
				end
				write_reg(spr_pkg::CFG_PATTERN_BYTES, word);
			end
			if (regs_mask[1]) begin
				word = {$urandom, $urandom};
				if ($urandom_range(0, 4) == 0) begin
					word[3:0] = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
				end else begin
					word[3:0] = 4'($urandom_range(1, 8));
				end
				write_reg(spr_pkg::CFG_PATTERN_LENGTH, word);
			end
			if (regs_mask[2]) begin
				write_reg(spr_pkg::CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
			end
			if (regs_mask[3]) begin
				word = {$urandom, $urandom};
				if ($urandom_range(0, 5) == 0) begin
					word[3:0] = 4'($urandom_range(9, 15));
				end else begin
					word[3:0] = 4'($urandom_range(0, 8));
				end
				write_reg(spr_pkg::CFG_REPLACEMENT_LENGTH, word);
			end

			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			goal = PHASE_BYTES;
			// One phase starves the result side while the source keeps offering.
			if (phase == HOLD_PHASE) begin
				tx_idle_on = 1'b0;
				hold_off_req = 1'b1;
				goal = 2 * PHASE_BYTES;
			end

			sent = 0;
			while (sent < goal) begin
				str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
					: $urandom_range(1, 16);
				for (k = 0; k < str_len; k++) begin
					push_byte(next_text_byte(), (k == str_len - 1), 1'b0, NO_WORD);
					sent++;
					// Mid-string pause until every word so far has come out.
					if (phase == PAUSE_PHASE && sent == PHASE_BYTES / 2) begin
						feed_quiet();
						while (expected_words.size() != 0) begin
							@(posedge clk);
						end
					end
				end
			end
			// Sometimes leave a string open across the next register writes.
			if ($urandom_range(0, 4) == 0) begin
				for (k = 0; k < $urandom_range(1, 6); k++) begin
					push_byte(next_text_byte(), 1'b0, 1'b0, NO_WORD);
				end
			end
		end

		// Close the last string, then drain.
		push_byte(next_text_byte(), 1'b1, 1'b0, NO_WORD);
		feed_quiet();
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// Result side: random stalls, one long hold-off on request.
	initial begin
		int unsigned stall;
		result_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = LONG_HOLD;
			end else if (rx_idle_on) begin
				stall = pick_gap();
			end else begin
				stall = 0;
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Compare each accepted word with the oldest expectation.
	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_words.size() == 0) begin
				$error("word with nothing expected: out_byte %0h byte_valid %0b out_last %0b",
					result_ch.out_byte, result_ch.byte_valid, result_ch.out_last);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (result_ch.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, result_ch.out_byte);
					mismatches++;
				end
				if (result_ch.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %0b, got %0b", want.byte_valid,
						result_ch.byte_valid);
					mismatches++;
				end
				if (result_ch.out_last !== want.out_last) begin
					$error("out_last: expected %0b, got %0b", want.out_last, result_ch.out_last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles with no word moving and no register write.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (feed_ch.valid && feed_ch.ready)
			|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
